// ----- rtl/core/prts_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and codes of the page range table.
package prts_pkg;

   localparam int ENTRIES     = 512;
   localparam int PAGE_BITS   = 28;

   localparam int MODE_W      = 2;
   localparam int IN_IDX_W    = 9;
   localparam int PAGE_PORT_W = 28;
   localparam int STATUS_W    = 2;

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int GRP_W  = (ENTRIES >= 32) ? 32 : (1 << $clog2(ENTRIES));
   localparam int GRP_N  = (ENTRIES + GRP_W - 1) / GRP_W;
   localparam int GSEL_W = (GRP_N > 1) ? $clog2(GRP_N) : 1;
   localparam int BSEL_W = $clog2(GRP_W);
   localparam int MAP_W  = GRP_N * GRP_W;
   localparam int MEM_W  = 2 * PAGE_BITS + 1;

   typedef logic [PAGE_BITS-1:0]   page_type;
   typedef logic [PAGE_PORT_W-1:0] pport_type;
   typedef logic [IDX_W-1:0]       slot_type;
   typedef logic [IN_IDX_W-1:0]    rindex_type;
   typedef logic [GSEL_W-1:0]      grp_type;
   typedef logic [BSEL_W-1:0]      bit_type;
   typedef logic [ENTRIES-1:0]     bitmap_type;
   typedef logic [MAP_W-1:0]       map_type;
   typedef logic [GRP_W-1:0]       gword_type;
   typedef logic [MEM_W-1:0]       word_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_INIT    = 2'd0,
      MODE_SPLIT   = 2'd1,
      MODE_RESERVE = 2'd2,
      MODE_READ    = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_GRP0,
      ST_BIT0,
      ST_GRP1,
      ST_BIT1,
      ST_WR_IDX,
      ST_WR_F0,
      ST_WR_F1
   } state_type;

endpackage

// ----- rtl/core/page_range_table_split_core.sv -----
`timescale 1ns / 1ps
// Page range table: init, split, reserve and read of page ranges held in one memory.
// Read, reserve and out-of-range requests strobe their result from the read state. A split on
// a full table strobes from the second bit search, else from the first free-slot write, or from
// the second with a lower piece; its free-slot search walks a group summary and then a 32-bit
// group, twice. Init sweeps the memory one entry a cycle and strobes once the last entry is
// written; busy drops with every strobe, so the next transfer can follow at the edge that ends
// the strobe cycle. After reset the same sweep runs with busy high; results cannot be stalled.
module page_range_table_split_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [prts_pkg::MODE_W-1:0]        req_mode,
   input  logic [prts_pkg::IN_IDX_W-1:0]      req_entry_index,
   input  logic [prts_pkg::PAGE_PORT_W-1:0]   req_range_start,
   input  logic [prts_pkg::PAGE_PORT_W-1:0]   req_range_end,
   output logic                               rsp_valid,
   output logic [prts_pkg::STATUS_W-1:0]      rsp_status,
   output logic [prts_pkg::IN_IDX_W-1:0]      rsp_result_index,
   output logic [prts_pkg::PAGE_PORT_W-1:0]   rsp_entry_start,
   output logic [prts_pkg::PAGE_PORT_W-1:0]   rsp_entry_end,
   output logic                               rsp_entry_used,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [prts_pkg::PAGE_PORT_W-1:0]   csr_data
);

   prts_pkg::state_type  state_ff, state_in;
   prts_pkg::slot_type   cnt_ff, cnt_in;
   logic                 init_ff, init_in;
   prts_pkg::bitmap_type bitmap_ff, bitmap_in;
   prts_pkg::page_type   total_ff, total_in;

   prts_pkg::mode_type   mode_ff, mode_in;
   prts_pkg::rindex_type idx_ff, idx_in;
   prts_pkg::slot_type   addr_ff, addr_in;
   prts_pkg::page_type   rs_ff, rs_in;
   prts_pkg::page_type   re_ff, re_in;
   prts_pkg::page_type   es_ff, es_in;
   prts_pkg::page_type   ee_ff, ee_in;
   logic                 eu_ff, eu_in;
   logic                 ue_ff, ue_in;
   logic                 ln_ff, ln_in;
   prts_pkg::grp_type    grp_ff, grp_in;
   logic                 grp_ok_ff, grp_ok_in;
   prts_pkg::slot_type   f0_ff, f0_in;
   logic                 f0_ok_ff, f0_ok_in;
   prts_pkg::slot_type   f1_ff, f1_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   prts_pkg::status_type   rsp_status_ff, rsp_status_in;
   prts_pkg::rindex_type   rsp_index_ff, rsp_index_in;
   prts_pkg::pport_type    rsp_start_ff, rsp_start_in;
   prts_pkg::pport_type    rsp_end_ff, rsp_end_in;
   logic                   rsp_used_ff, rsp_used_in;

   prts_pkg::word_type   mem [prts_pkg::ENTRIES];
   prts_pkg::word_type   rd_data_ff;
   logic                 mem_rd_en;
   prts_pkg::slot_type   mem_rd_addr;
   logic                 mem_wr_en;
   prts_pkg::slot_type   mem_wr_addr;
   prts_pkg::word_type   mem_wr_data;

   logic                 accept;
   logic                 clear_last;
   logic                 idx_bad;
   logic                 range_bad;
   prts_pkg::page_type   rd_start;
   prts_pkg::page_type   rd_end;
   logic                 rd_used;

   prts_pkg::bitmap_type   free_map;
   prts_pkg::map_type      eff_map;
   logic [prts_pkg::GRP_N-1:0] grp_any;
   prts_pkg::grp_type      grp_sel;
   logic                   grp_hit;
   prts_pkg::gword_type    grp_word;
   prts_pkg::bit_type      bit_sel;
   logic                   bit_hit;
   prts_pkg::slot_type     slot_found;
   logic                   slot_ok;
   logic                   split_full;

   assign busy             = (state_ff != prts_pkg::ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_entry_start  = rsp_start_ff;
   assign rsp_entry_end    = rsp_end_ff;
   assign rsp_entry_used   = rsp_used_ff;

   assign accept     = start && (state_ff == prts_pkg::ST_IDLE);
   assign clear_last = (cnt_ff == prts_pkg::slot_type'(prts_pkg::ENTRIES - 1));
   assign idx_bad    = (int'(idx_ff) >= prts_pkg::ENTRIES);
   assign rd_start   = rd_data_ff[prts_pkg::PAGE_BITS-1:0];
   assign rd_end     = rd_data_ff[2*prts_pkg::PAGE_BITS-1:prts_pkg::PAGE_BITS];
   assign rd_used    = rd_data_ff[prts_pkg::MEM_W-1];
   assign range_bad  = (rs_ff < rd_start) || (re_ff > rd_end) || (rs_ff > re_ff);

   // Free map as seen by this split: the split entry counts as free when its upper part
   // empties, and the first slot found is masked out for the second search.
   always_comb begin
      free_map = bitmap_ff;
      if (ue_ff) begin
         free_map[addr_ff] = 1'b1;
      end
      if ((state_ff == prts_pkg::ST_GRP1) || (state_ff == prts_pkg::ST_BIT1)) begin
         free_map[f0_ff] = 1'b0;
      end
      eff_map = prts_pkg::map_type'(free_map);
   end

   always_comb begin
      grp_sel = '0;
      for (int g = prts_pkg::GRP_N - 1; g >= 0; g--) begin
         grp_any[g] = |eff_map[g*prts_pkg::GRP_W +: prts_pkg::GRP_W];
         if (grp_any[g]) begin
            grp_sel = prts_pkg::grp_type'(g);
         end
      end
      grp_hit = |grp_any;
   end

   always_comb begin
      grp_word = eff_map[grp_ff*prts_pkg::GRP_W +: prts_pkg::GRP_W];
      bit_sel  = '0;
      for (int b = prts_pkg::GRP_W - 1; b >= 0; b--) begin
         if (grp_word[b]) begin
            bit_sel = prts_pkg::bit_type'(b);
         end
      end
      bit_hit    = |grp_word;
      slot_found = prts_pkg::slot_type'({grp_ff, bit_sel});
      slot_ok    = grp_ok_ff && bit_hit;
   end

   assign split_full = !f0_ok_ff || (ln_ff && !slot_ok);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         prts_pkg::ST_CLEAR: begin
            if (clear_last) begin
               state_in = prts_pkg::ST_IDLE;
            end
         end
         prts_pkg::ST_IDLE: begin
            if (accept) begin
               if (prts_pkg::mode_type'(req_mode) == prts_pkg::MODE_INIT) begin
                  state_in = prts_pkg::ST_CLEAR;
               end else begin
                  state_in = prts_pkg::ST_READ;
               end
            end
         end
         prts_pkg::ST_READ: begin
            if (!idx_bad && (mode_ff == prts_pkg::MODE_SPLIT) && !range_bad) begin
               state_in = prts_pkg::ST_GRP0;
            end else begin
               state_in = prts_pkg::ST_IDLE;
            end
         end
         prts_pkg::ST_GRP0:   state_in = prts_pkg::ST_BIT0;
         prts_pkg::ST_BIT0:   state_in = prts_pkg::ST_GRP1;
         prts_pkg::ST_GRP1:   state_in = prts_pkg::ST_BIT1;
         prts_pkg::ST_BIT1: begin
            if (split_full) begin
               state_in = prts_pkg::ST_IDLE;
            end else begin
               state_in = prts_pkg::ST_WR_IDX;
            end
         end
         prts_pkg::ST_WR_IDX: state_in = prts_pkg::ST_WR_F0;
         prts_pkg::ST_WR_F0: begin
            if (ln_ff) begin
               state_in = prts_pkg::ST_WR_F1;
            end else begin
               state_in = prts_pkg::ST_IDLE;
            end
         end
         prts_pkg::ST_WR_F1:  state_in = prts_pkg::ST_IDLE;
         default:             state_in = prts_pkg::ST_IDLE;
      endcase
   end

   // Memory controls and the result.
   always_comb begin
      mem_rd_en     = 1'b0;
      mem_rd_addr   = prts_pkg::slot_type'(req_entry_index);
      mem_wr_en     = 1'b0;
      mem_wr_addr   = addr_ff;
      mem_wr_data   = '0;
      rsp_valid_in  = 1'b0;
      rsp_status_in = prts_pkg::STATUS_DONE;
      rsp_index_in  = idx_ff;
      rsp_start_in  = '0;
      rsp_end_in    = '0;
      rsp_used_in   = 1'b0;
      unique case (state_ff)
         prts_pkg::ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cnt_ff;
            if (init_ff && (cnt_ff == '0)) begin
               mem_wr_data = {1'b0, total_ff, {prts_pkg::PAGE_BITS{1'b0}}};
            end
            if (clear_last && init_ff) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = '0;
               rsp_end_in   = prts_pkg::pport_type'(total_ff);
            end
         end
         prts_pkg::ST_IDLE: begin
            mem_rd_en = accept;
         end
         prts_pkg::ST_READ: begin
            if (idx_bad) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = prts_pkg::STATUS_RANGE;
            end else begin
               unique case (mode_ff)
                  prts_pkg::MODE_RESERVE: begin
                     mem_wr_en    = 1'b1;
                     mem_wr_data  = {1'b1, rd_end, rd_start};
                     rsp_valid_in = 1'b1;
                     rsp_start_in = prts_pkg::pport_type'(rd_start);
                     rsp_end_in   = prts_pkg::pport_type'(rd_end);
                     rsp_used_in  = 1'b1;
                  end
                  prts_pkg::MODE_READ: begin
                     rsp_valid_in = 1'b1;
                     rsp_start_in = prts_pkg::pport_type'(rd_start);
                     rsp_end_in   = prts_pkg::pport_type'(rd_end);
                     rsp_used_in  = rd_used;
                  end
                  prts_pkg::MODE_SPLIT: begin
                     if (range_bad) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = prts_pkg::STATUS_RANGE;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end
         prts_pkg::ST_BIT1: begin
            if (split_full) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = prts_pkg::STATUS_FULL;
            end
         end
         prts_pkg::ST_WR_IDX: begin
            mem_wr_en = 1'b1;
            if (!ue_ff) begin
               mem_wr_data = {eu_ff, ee_ff, re_ff};
            end
         end
         prts_pkg::ST_WR_F0: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = f0_ff;
            mem_wr_data = {1'b0, re_ff, rs_ff};
            if (!ln_ff) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = prts_pkg::rindex_type'(f0_ff);
               rsp_start_in = prts_pkg::pport_type'(rs_ff);
               rsp_end_in   = prts_pkg::pport_type'(re_ff);
            end
         end
         prts_pkg::ST_WR_F1: begin
            mem_wr_en    = 1'b1;
            mem_wr_addr  = f1_ff;
            mem_wr_data  = {1'b0, rs_ff, es_ff};
            rsp_valid_in = 1'b1;
            rsp_index_in = prts_pkg::rindex_type'(f0_ff);
            rsp_start_in = prts_pkg::pport_type'(rs_ff);
            rsp_end_in   = prts_pkg::pport_type'(re_ff);
         end
         default: begin
            mem_rd_en = 1'b0;
         end
      endcase
   end

   // Datapath registers.
   always_comb begin
      cnt_in    = cnt_ff;
      init_in   = init_ff;
      bitmap_in = bitmap_ff;
      total_in  = total_ff;
      mode_in   = mode_ff;
      idx_in    = idx_ff;
      addr_in   = addr_ff;
      rs_in     = rs_ff;
      re_in     = re_ff;
      es_in     = es_ff;
      ee_in     = ee_ff;
      eu_in     = eu_ff;
      ue_in     = ue_ff;
      ln_in     = ln_ff;
      grp_in    = grp_ff;
      grp_ok_in = grp_ok_ff;
      f0_in     = f0_ff;
      f0_ok_in  = f0_ok_ff;
      f1_in     = f1_ff;
      if (csr_valid) begin
         total_in = prts_pkg::page_type'(csr_data);
      end
      unique case (state_ff)
         prts_pkg::ST_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (clear_last) begin
               init_in = 1'b0;
            end
         end
         prts_pkg::ST_IDLE: begin
            ue_in = 1'b0;
            if (accept) begin
               mode_in = prts_pkg::mode_type'(req_mode);
               idx_in  = req_entry_index;
               addr_in = prts_pkg::slot_type'(req_entry_index);
               rs_in   = prts_pkg::page_type'(req_range_start);
               re_in   = prts_pkg::page_type'(req_range_end);
               if (prts_pkg::mode_type'(req_mode) == prts_pkg::MODE_INIT) begin
                  cnt_in       = '0;
                  init_in      = 1'b1;
                  bitmap_in    = '1;
                  bitmap_in[0] = (total_ff == '0);
               end
            end
         end
         prts_pkg::ST_READ: begin
            es_in = rd_start;
            ee_in = rd_end;
            eu_in = rd_used;
            ue_in = (re_ff == rd_end);
            ln_in = (rs_ff != rd_start);
         end
         prts_pkg::ST_GRP0, prts_pkg::ST_GRP1: begin
            grp_in    = grp_sel;
            grp_ok_in = grp_hit;
         end
         prts_pkg::ST_BIT0: begin
            f0_in    = slot_found;
            f0_ok_in = slot_ok;
         end
         prts_pkg::ST_BIT1: begin
            f1_in    = slot_found;
         end
         prts_pkg::ST_WR_IDX: begin
            bitmap_in[addr_ff] = ue_ff;
         end
         prts_pkg::ST_WR_F0: begin
            bitmap_in[f0_ff] = (rs_ff == '0) && (re_ff == '0);
         end
         prts_pkg::ST_WR_F1: begin
            bitmap_in[f1_ff] = 1'b0;
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prts_pkg::ST_CLEAR;
         cnt_ff       <= '0;
         init_ff      <= 1'b0;
         bitmap_ff    <= '1;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         init_ff      <= init_in;
         bitmap_ff    <= bitmap_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      idx_ff        <= idx_in;
      addr_ff       <= addr_in;
      rs_ff         <= rs_in;
      re_ff         <= re_in;
      es_ff         <= es_in;
      ee_ff         <= ee_in;
      eu_ff         <= eu_in;
      ue_ff         <= ue_in;
      ln_ff         <= ln_in;
      grp_ff        <= grp_in;
      grp_ok_ff     <= grp_ok_in;
      f0_ff         <= f0_in;
      f0_ok_ff      <= f0_ok_in;
      f1_ff         <= f1_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_used_ff   <= rsp_used_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= mem[mem_rd_addr];
      end
   end

endmodule

// ----- rtl/core/prts_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the page range table, bound to the top level.
module prts_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic [prts_pkg::MODE_W-1:0]        req_mode,
   input logic [prts_pkg::IN_IDX_W-1:0]      req_entry_index,
   input logic [prts_pkg::PAGE_PORT_W-1:0]   req_range_start,
   input logic [prts_pkg::PAGE_PORT_W-1:0]   req_range_end,
   input logic                               rsp_valid,
   input logic [prts_pkg::STATUS_W-1:0]      rsp_status,
   input logic [prts_pkg::IN_IDX_W-1:0]      rsp_result_index,
   input logic [prts_pkg::PAGE_PORT_W-1:0]   rsp_entry_start,
   input logic [prts_pkg::PAGE_PORT_W-1:0]   rsp_entry_end,
   input logic                               rsp_entry_used,
   input logic                               csr_valid,
   input logic                               csr_ready,
   input logic [prts_pkg::PAGE_PORT_W-1:0]   csr_data
);

   // Every accepted request keeps the block busy for at least the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request transfer not followed by busy");

   // A result only appears as the block finishes a request.
   a_rsp_ends_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result strobe without preceding busy period");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // A failed request reports no entry contents.
   a_fail_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != prts_pkg::STATUS_DONE)) |->
      ((rsp_entry_start == '0) && (rsp_entry_end == '0) && !rsp_entry_used))
      else $error("failed result carries entry contents");

endmodule

bind page_range_table_split_core prts_checker u_prts_checker (.*);
